// ===== hdl/arpfc_pkg.sv =====
package arpfc_pkg;

   localparam int HW_ADDR_BYTES = 6;
   localparam int IP_BYTES = 4;
   localparam int HW_ADDR_W = HW_ADDR_BYTES * 8;
   localparam int IP_W = IP_BYTES * 8;
   localparam int COUNT_W = 5;

   // byte offsets inside the arp body
   localparam logic [COUNT_W-1:0] OFF_PROTO = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] OFF_HLEN = COUNT_W'(4);
   localparam logic [COUNT_W-1:0] OFF_PLEN = COUNT_W'(5);
   localparam logic [COUNT_W-1:0] OFF_SHA = COUNT_W'(8);
   localparam logic [COUNT_W-1:0] OFF_SIP = COUNT_W'(8 + HW_ADDR_BYTES);
   localparam logic [COUNT_W-1:0] OFF_THA = COUNT_W'(8 + HW_ADDR_BYTES + IP_BYTES);
   localparam logic [COUNT_W-1:0] OFF_TIP = COUNT_W'(8 + 2 * HW_ADDR_BYTES + IP_BYTES);
   localparam logic [COUNT_W-1:0] BODY_LEN = COUNT_W'(8 + 2 * HW_ADDR_BYTES + 2 * IP_BYTES);

   localparam logic [15:0] HW_TYPE_RESET = 16'h0001;
   localparam logic [15:0] PROTO_IPV4 = 16'h0800;
   localparam logic [15:0] OPCODE_REQUEST = 16'h0001;
   localparam logic [15:0] OPCODE_REPLY = 16'h0002;

   localparam logic [2:0] CLASS_OTHER_HOST = 3'd3;
   localparam logic [2:0] CLASS_LOOPBACK = 3'd4;

   localparam logic [2:0] STATUS_SHORT = 3'd0;
   localparam logic [2:0] STATUS_BAD_LEN = 3'd1;
   localparam logic [2:0] STATUS_BAD_PROTO = 3'd2;
   localparam logic [2:0] STATUS_BAD_OPCODE = 3'd3;
   localparam logic [2:0] STATUS_BAD_TARGET = 3'd4;
   localparam logic [2:0] STATUS_REQUEST = 3'd5;
   localparam logic [2:0] STATUS_REPLY = 3'd6;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [2:0] cls;
      logic [15:0] hw_type;
      logic [15:0] proto;
      logic [7:0] hlen;
      logic [7:0] plen;
      logic [15:0] opcode;
      logic [HW_ADDR_W-1:0] sha;
      logic [IP_W-1:0] sip;
      logic [HW_ADDR_W-1:0] tha;
      logic [IP_W-1:0] tip;
   } frame_type;

   typedef struct packed {
      logic fire;
      logic last;
   } step_type;

endpackage

// ===== hdl/arpfc_capture.sv =====
module arpfc_capture (
   input  logic clock,
   input  logic reset,
   input  arpfc_pkg::step_type step,
   input  logic [7:0] data_byte,
   input  logic [2:0] frame_class,
   output arpfc_pkg::frame_type frame_view
);

   arpfc_pkg::frame_type state_ff;
   arpfc_pkg::frame_type state_in;
   logic [arpfc_pkg::COUNT_W-1:0] pos;

   assign pos = state_ff.count;

   // state as it stands once this item is taken in
   always_comb begin
      state_in = state_ff;
      if (pos == '0) begin
         state_in.cls = frame_class;
      end
      if (pos < arpfc_pkg::BODY_LEN) begin
         if (pos < arpfc_pkg::OFF_PROTO) begin
            state_in.hw_type = {state_ff.hw_type[7:0], data_byte};
         end else if (pos < arpfc_pkg::OFF_HLEN) begin
            state_in.proto = {state_ff.proto[7:0], data_byte};
         end else if (pos == arpfc_pkg::OFF_HLEN) begin
            state_in.hlen = data_byte;
         end else if (pos == arpfc_pkg::OFF_PLEN) begin
            state_in.plen = data_byte;
         end else if (pos < arpfc_pkg::OFF_SHA) begin
            state_in.opcode = {state_ff.opcode[7:0], data_byte};
         end else if (pos < arpfc_pkg::OFF_SIP) begin
            state_in.sha = {state_ff.sha[arpfc_pkg::HW_ADDR_W-9:0], data_byte};
         end else if (pos < arpfc_pkg::OFF_THA) begin
            state_in.sip = {state_ff.sip[arpfc_pkg::IP_W-9:0], data_byte};
         end else if (pos < arpfc_pkg::OFF_TIP) begin
            state_in.tha = {state_ff.tha[arpfc_pkg::HW_ADDR_W-9:0], data_byte};
         end else begin
            state_in.tip = {state_ff.tip[arpfc_pkg::IP_W-9:0], data_byte};
         end
         state_in.count = arpfc_pkg::COUNT_W'(pos + 1'b1);
      end
   end

   assign frame_view = state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step.fire) begin
         // a verdict closes the frame, so the next item starts afresh
         state_ff <= step.last ? '0 : state_in;
      end
   end

   count_saturates: assert property (@(posedge clock) disable iff (reset)
      state_ff.count <= arpfc_pkg::BODY_LEN)
      else $error("byte count ran past the arp body");

   last_clears_frame: assert property (@(posedge clock) disable iff (reset)
      step.fire && step.last |=> state_ff == '0)
      else $error("frame state not cleared after a verdict");

endmodule

// ===== hdl/arpfc_verdict.sv =====
module arpfc_verdict (
   input  logic clock,
   input  logic reset,
   input  arpfc_pkg::step_type step,
   input  arpfc_pkg::frame_type frame_view,
   input  logic [15:0] hw_type,
   input  logic rsp_stall,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [arpfc_pkg::HW_ADDR_W-1:0] rsp_sender_hw,
   output logic [arpfc_pkg::IP_W-1:0] rsp_sender_ip,
   output logic [arpfc_pkg::HW_ADDR_W-1:0] rsp_target_hw,
   output logic [arpfc_pkg::IP_W-1:0] rsp_target_ip
);

   logic rsp_valid_ff;
   logic [2:0] status_ff;
   logic [2:0] status_in;
   logic [arpfc_pkg::HW_ADDR_W-1:0] sender_hw_ff;
   logic [arpfc_pkg::IP_W-1:0] sender_ip_ff;
   logic [arpfc_pkg::HW_ADDR_W-1:0] target_hw_ff;
   logic [arpfc_pkg::IP_W-1:0] target_ip_ff;
   logic [7:0] top_octet;

   assign top_octet = frame_view.tip[arpfc_pkg::IP_W-1 -: 8];

   // checks in priority order
   always_comb begin
      if (frame_view.count < arpfc_pkg::BODY_LEN) begin
         status_in = arpfc_pkg::STATUS_SHORT;
      end else if (frame_view.hlen != 8'(arpfc_pkg::HW_ADDR_BYTES)
                   || frame_view.plen != 8'(arpfc_pkg::IP_BYTES)
                   || frame_view.cls == arpfc_pkg::CLASS_OTHER_HOST
                   || frame_view.cls == arpfc_pkg::CLASS_LOOPBACK) begin
         status_in = arpfc_pkg::STATUS_BAD_LEN;
      end else if (frame_view.proto != arpfc_pkg::PROTO_IPV4
                   || frame_view.hw_type != hw_type) begin
         status_in = arpfc_pkg::STATUS_BAD_PROTO;
      end else if (frame_view.opcode != arpfc_pkg::OPCODE_REQUEST
                   && frame_view.opcode != arpfc_pkg::OPCODE_REPLY) begin
         status_in = arpfc_pkg::STATUS_BAD_OPCODE;
      end else if (top_octet inside {8'd127, [8'd224:8'd239]}) begin
         // loopback or multicast target
         status_in = arpfc_pkg::STATUS_BAD_TARGET;
      end else if (frame_view.opcode == arpfc_pkg::OPCODE_REQUEST) begin
         status_in = arpfc_pkg::STATUS_REQUEST;
      end else begin
         status_in = arpfc_pkg::STATUS_REPLY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step.fire && step.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step.fire && step.last) begin
         status_ff <= status_in;
         sender_hw_ff <= frame_view.sha;
         sender_ip_ff <= frame_view.sip;
         target_hw_ff <= frame_view.tha;
         target_ip_ff <= frame_view.tip;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_sender_hw = sender_hw_ff;
   assign rsp_sender_ip = sender_ip_ff;
   assign rsp_target_hw = target_hw_ff;
   assign rsp_target_ip = target_ip_ff;

   status_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> status_ff <= arpfc_pkg::STATUS_REPLY)
      else $error("status code out of range");

   good_target_on_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == arpfc_pkg::STATUS_REQUEST
                       || status_ff == arpfc_pkg::STATUS_REPLY)
      |-> target_ip_ff[arpfc_pkg::IP_W-1 -: 8] != 8'd127)
      else $error("loopback target passed the checks");

endmodule

// ===== hdl/arp_frame_checker.sv =====
// arp frame checker
// req channel: one byte of the arp payload per item, in wire order, with the
// frame's delivery class (taken from the first byte) and a last-byte flag.
// An item moves on an edge where req_valid is high and req_stall is low.
// rsp channel: one verdict item per frame, raised for the byte flagged last,
// with the status code and the sender and target addresses of the frame.
// Bytes beyond the 28-byte arp body are padding and change nothing.
// csr channel: csr_data sets the expected hardware type; csr_ready is always
// high and a write should only be made while no frame is under way.
// Throughput: one byte per cycle while req_stall is low, set by the input register
// feeding the frame capture registers. A last byte passes through the input
// register and then the result register before its verdict shows on rsp_valid.
// While a verdict waits under rsp_stall, non-last bytes of the next frame
// still flow; a further last byte is held and req_stall rises until the
// waiting verdict is taken.
// Reset (synchronous, active high) clears the frame state and both valids
// and sets the hardware type to 1.
module arp_frame_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_data_byte,
   input  logic [2:0] req_frame_class,
   input  logic req_last_byte,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic [arpfc_pkg::HW_ADDR_W-1:0] rsp_sender_hw,
   output logic [arpfc_pkg::IP_W-1:0] rsp_sender_ip,
   output logic [arpfc_pkg::HW_ADDR_W-1:0] rsp_target_hw,
   output logic [arpfc_pkg::IP_W-1:0] rsp_target_ip,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [15:0] csr_data
);

   logic [15:0] hw_type_ff;
   logic in_valid_ff;
   logic [7:0] in_byte_ff;
   logic [2:0] in_class_ff;
   logic in_last_ff;
   logic hold;
   logic req_accept;
   arpfc_pkg::step_type step;
   arpfc_pkg::frame_type frame_view;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_type_ff <= arpfc_pkg::HW_TYPE_RESET;
      end else if (csr_valid && csr_ready) begin
         hw_type_ff <= csr_data;
      end
   end

   // a last byte waits only when the result register is full and stalled
   assign hold = in_valid_ff && in_last_ff && rsp_valid && rsp_stall;
   assign req_stall = hold;
   assign req_accept = req_valid && !req_stall;

   assign step.fire = in_valid_ff && !hold;
   assign step.last = in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!hold) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_data_byte;
         in_class_ff <= req_frame_class;
         in_last_ff <= req_last_byte;
      end
   end

   arpfc_capture u_capture (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_byte_ff),
      .frame_class (in_class_ff),
      .frame_view  (frame_view)
   );

   arpfc_verdict u_verdict (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .frame_view    (frame_view),
      .hw_type       (hw_type_ff),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_sender_hw (rsp_sender_hw),
      .rsp_sender_ip (rsp_sender_ip),
      .rsp_target_hw (rsp_target_hw),
      .rsp_target_ip (rsp_target_ip)
   );

   held_item_kept: assert property (@(posedge clock) disable iff (reset)
      hold |=> in_valid_ff && in_last_ff)
      else $error("held last byte lost from the input register");

endmodule

// ===== tb/sv/arp_frame_checker_test.sv =====
`timescale 1ns / 1ps

module arp_frame_checker_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASES = 6;

   typedef struct {
      logic [7:0] data;
      logic [2:0] cls;
      logic last;
   } wire_byte_type;

   typedef struct {
      logic [2:0] status;
      logic [arpfc_pkg::HW_ADDR_W-1:0] sha;
      logic [arpfc_pkg::IP_W-1:0] sip;
      logic [arpfc_pkg::HW_ADDR_W-1:0] tha;
      logic [arpfc_pkg::IP_W-1:0] tip;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_data_byte = 8'd0;
   logic [2:0] req_frame_class = 3'd0;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [arpfc_pkg::HW_ADDR_W-1:0] rsp_sender_hw;
   logic [arpfc_pkg::IP_W-1:0] rsp_sender_ip;
   logic [arpfc_pkg::HW_ADDR_W-1:0] rsp_target_hw;
   logic [arpfc_pkg::IP_W-1:0] rsp_target_ip;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_data = 16'd0;

   arp_frame_checker i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_frame_class(req_frame_class),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_sender_hw(rsp_sender_hw),
      .rsp_sender_ip(rsp_sender_ip),
      .rsp_target_hw(rsp_target_hw),
      .rsp_target_ip(rsp_target_ip),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   wire_byte_type wire_bytes[$];
   verdict_type verdicts_due[$];
   wire_byte_type offered;
   int queued_total = 0;
   int accepted_total = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;

   // frame capture mirror
   logic [15:0] hw_type_reg = arpfc_pkg::HW_TYPE_RESET;
   logic [arpfc_pkg::COUNT_W-1:0] fs_count = '0;
   logic [2:0] fs_class = '0;
   logic [15:0] fs_hw = '0;
   logic [15:0] fs_proto = '0;
   logic [7:0] fs_hlen = '0;
   logic [7:0] fs_plen = '0;
   logic [15:0] fs_opcode = '0;
   logic [arpfc_pkg::HW_ADDR_W-1:0] fs_sha = '0;
   logic [arpfc_pkg::IP_W-1:0] fs_sip = '0;
   logic [arpfc_pkg::HW_ADDR_W-1:0] fs_tha = '0;
   logic [arpfc_pkg::IP_W-1:0] fs_tip = '0;

   function automatic logic [2:0] judge_frame();
      if (fs_count < arpfc_pkg::BODY_LEN) return arpfc_pkg::STATUS_SHORT;
      if (fs_hlen != 8'(arpfc_pkg::HW_ADDR_BYTES) || fs_plen != 8'(arpfc_pkg::IP_BYTES) ||
          fs_class == arpfc_pkg::CLASS_OTHER_HOST || fs_class == arpfc_pkg::CLASS_LOOPBACK)
         return arpfc_pkg::STATUS_BAD_LEN;
      if (fs_proto != arpfc_pkg::PROTO_IPV4 || fs_hw != hw_type_reg)
         return arpfc_pkg::STATUS_BAD_PROTO;
      if (fs_opcode != arpfc_pkg::OPCODE_REQUEST && fs_opcode != arpfc_pkg::OPCODE_REPLY)
         return arpfc_pkg::STATUS_BAD_OPCODE;
      if (fs_tip[31:24] == 8'd127 || (fs_tip[31:24] >= 8'd224 && fs_tip[31:24] <= 8'd239))
         return arpfc_pkg::STATUS_BAD_TARGET;
      return (fs_opcode == arpfc_pkg::OPCODE_REQUEST) ? arpfc_pkg::STATUS_REQUEST
                                                      : arpfc_pkg::STATUS_REPLY;
   endfunction

   task automatic absorb_byte(input wire_byte_type item);
      verdict_type v;
      if (fs_count == 0) fs_class = item.cls;
      if (fs_count < arpfc_pkg::BODY_LEN) begin
         if (fs_count < arpfc_pkg::OFF_PROTO) fs_hw = {fs_hw[7:0], item.data};
         else if (fs_count < arpfc_pkg::OFF_HLEN) fs_proto = {fs_proto[7:0], item.data};
         else if (fs_count == arpfc_pkg::OFF_HLEN) fs_hlen = item.data;
         else if (fs_count == arpfc_pkg::OFF_PLEN) fs_plen = item.data;
         else if (fs_count < arpfc_pkg::OFF_SHA) fs_opcode = {fs_opcode[7:0], item.data};
         else if (fs_count < arpfc_pkg::OFF_SIP)
            fs_sha = {fs_sha[arpfc_pkg::HW_ADDR_W-9:0], item.data};
         else if (fs_count < arpfc_pkg::OFF_THA)
            fs_sip = {fs_sip[arpfc_pkg::IP_W-9:0], item.data};
         else if (fs_count < arpfc_pkg::OFF_TIP)
            fs_tha = {fs_tha[arpfc_pkg::HW_ADDR_W-9:0], item.data};
         else fs_tip = {fs_tip[arpfc_pkg::IP_W-9:0], item.data};
         fs_count++;
      end
      if (item.last) begin
         v.status = judge_frame();
         v.sha = fs_sha;
         v.sip = fs_sip;
         v.tha = fs_tha;
         v.tip = fs_tip;
         verdicts_due.push_back(v);
         fs_count = '0;
         fs_class = '0;
         fs_hw = '0;
         fs_proto = '0;
         fs_hlen = '0;
         fs_plen = '0;
         fs_opcode = '0;
         fs_sha = '0;
         fs_sip = '0;
         fs_tha = '0;
         fs_tip = '0;
      end
   endtask

   function automatic logic [223:0] arp_body(input logic [15:0] hw, input logic [15:0] proto,
                                             input logic [7:0] hlen, input logic [7:0] plen,
                                             input logic [15:0] op,
                                             input logic [arpfc_pkg::HW_ADDR_W-1:0] sha,
                                             input logic [arpfc_pkg::IP_W-1:0] sip,
                                             input logic [arpfc_pkg::HW_ADDR_W-1:0] tha,
                                             input logic [arpfc_pkg::IP_W-1:0] tip);
      return {hw, proto, hlen, plen, op, sha, sip, tha, tip};
   endfunction

   // keep: body bytes sent (1..28), pad: trailing bytes after a full body
   task automatic queue_frame(input logic [223:0] body, input int keep, input int pad,
                              input logic [2:0] cls);
      wire_byte_type item;
      int total;
      total = (keep < 28) ? keep : keep + pad;
      for (int i = 0; i < total; i++) begin
         item.data = (i < keep) ? body[223 - 8 * i -: 8] : 8'($urandom);
         // class only matters on the first byte of a frame
         item.cls = (i == 0) ? cls : 3'($urandom_range(7));
         item.last = (i == total - 1);
         wire_bytes.push_back(item);
         queued_total++;
      end
   endtask

   task automatic queue_random_frame(output int length);
      logic [15:0] hw, proto, op;
      logic [7:0] hlen, plen;
      logic [arpfc_pkg::HW_ADDR_W-1:0] sha, tha;
      logic [arpfc_pkg::IP_W-1:0] sip, tip;
      logic [2:0] cls;
      logic [223:0] body;
      int keep, pad, pick;
      hw = hw_type_reg;
      proto = arpfc_pkg::PROTO_IPV4;
      hlen = 8'(arpfc_pkg::HW_ADDR_BYTES);
      plen = 8'(arpfc_pkg::IP_BYTES);
      op = ($urandom_range(1)) ? arpfc_pkg::OPCODE_REQUEST : arpfc_pkg::OPCODE_REPLY;
      sha = {16'($urandom), 32'($urandom)};
      tha = {16'($urandom), 32'($urandom)};
      sip = $urandom;
      tip = $urandom;
      case ($urandom_range(9))
         0: tip[31:24] = 8'd127;
         1: tip[31:24] = 8'($urandom_range(224, 239));
         2: tip[31:24] = ($urandom_range(1)) ? 8'd223 : 8'd240;
         default: ;
      endcase
      cls = 3'($urandom_range(2));
      keep = 28;
      pad = ($urandom_range(3) != 0) ? $urandom_range(3) : $urandom_range(20);
      pick = $urandom_range(99);
      if (pick < 10) begin
         body = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         body = body ^ {$urandom, 192'd0};
         keep = $urandom_range(1, 28);
         cls = 3'($urandom_range(7));
      end else begin
         if (pick < 35) begin
            case ($urandom_range(7))
               0: hlen = 8'($urandom);
               1: plen = 8'($urandom);
               2: cls = ($urandom_range(1)) ? arpfc_pkg::CLASS_OTHER_HOST
                                            : arpfc_pkg::CLASS_LOOPBACK;
               3: proto = 16'($urandom);
               4: hw = 16'($urandom);
               5: op = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(3));
               6: keep = $urandom_range(1, 27);
               default: cls = 3'($urandom_range(5, 7));
            endcase
         end
         body = arp_body(hw, proto, hlen, plen, op, sha, sip, tha, tip);
      end
      queue_frame(body, keep, pad, cls);
      length = (keep < 28) ? keep : keep + pad;
   endtask

   task automatic write_hw_type(input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      hw_type_reg = value;
   endtask

   task automatic wait_drained();
      while (accepted_total != queued_total || verdicts_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [47:0] want,
                              input logic [47:0] seen);
      if (seen !== want) begin
         mismatches++;
         $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, seen);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_byte(offered);
            accepted_total++;
         end
         if (!req_valid || !req_stall) begin
            if (wire_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = wire_bytes.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= offered.data;
               req_frame_class <= offered.cls;
               req_last_byte <= offered.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            mismatches++;
            $display("%0t: verdict with none expected, status %0d", $time, rsp_status);
         end else begin
            want = verdicts_due.pop_front();
            check_field("rsp_status", 48'(want.status), 48'(rsp_status));
            check_field("rsp_sender_hw", want.sha, rsp_sender_hw);
            check_field("rsp_sender_ip", 48'(want.sip), 48'(rsp_sender_ip));
            check_field("rsp_target_hw", want.tha, rsp_target_hw);
            check_field("rsp_target_ip", 48'(want.tip), 48'(rsp_target_ip));
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_armed && !hold_done && rsp_valid) begin
         // long hold-off so the block backs up and stalls its input
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("arp_frame_checker verification failed");
         $finish;
      end
   end

   initial begin
      logic [15:0] hw_settings [PHASES];
      int send_pct [PHASES];
      int recv_pct [PHASES];
      int phase_bytes, len;
      hw_settings = '{16'h0001, 16'h0000, 16'hFFFF, 16'h0006, 16'h0000, 16'h0001};
      send_pct = '{15, 83, 0, 15, 83, 0};
      recv_pct = '{83, 15, 0, 83, 15, 0};
      hw_settings[4] = 16'($urandom);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed frames, no idling
      write_hw_type(arpfc_pkg::HW_TYPE_RESET);
      queue_frame(arp_body(16'h0001, arpfc_pkg::PROTO_IPV4, 8'd6, 8'd4,
                           arpfc_pkg::OPCODE_REQUEST, '1, '1, '0, 32'h0a000001),
                  1, 0, arpfc_pkg::CLASS_LOOPBACK);
      queue_frame(arp_body(16'h0001, arpfc_pkg::PROTO_IPV4, 8'd6, 8'd4,
                           arpfc_pkg::OPCODE_REQUEST, '1, '1, '0, 32'h0a000001),
                  28, 2, 3'd7);
      queue_frame(arp_body(16'h0001, arpfc_pkg::PROTO_IPV4, 8'd6, 8'd4,
                           arpfc_pkg::OPCODE_REPLY, 48'h0000_0000_0001, 32'hc0a80101, '1,
                           32'hdfffffff), 28, 0, 3'd2);
      queue_frame(arp_body(16'h0001, arpfc_pkg::PROTO_IPV4, 8'd6, 8'd4,
                           arpfc_pkg::OPCODE_REPLY, 48'h0200_0000_0001, 32'h0a000002, '0,
                           32'he0000001), 28, 0, 3'd1);
      queue_frame(arp_body(16'h0001, arpfc_pkg::PROTO_IPV4, 8'd6, 8'd4,
                           arpfc_pkg::OPCODE_REQUEST, 48'h0200_0000_0002, 32'h0a000003, '0,
                           32'h7f000001), 27, 0, 3'd0);
      queue_frame(arp_body(16'h0001, arpfc_pkg::PROTO_IPV4, 8'd6, 8'd4, 16'h0003,
                           48'h0200_0000_0003, 32'h0a000004, '0, 32'hf0000001), 28, 0,
                  arpfc_pkg::CLASS_OTHER_HOST);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         write_hw_type(hw_settings[p]);
         send_idle_pct = send_pct[p];
         recv_idle_pct = recv_pct[p];
         hold_armed = (send_pct[p] == 0);
         phase_bytes = 0;
         while (phase_bytes < 110) begin
            queue_random_frame(len);
            phase_bytes += len;
         end
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("arp_frame_checker verification clean");
      end else begin
         $display("arp_frame_checker verification failed");
      end
      $finish;
   end

endmodule
